/* hw/rtl/kvts_pkg.sv */
// Shared types and constants for the keyframe vector track sampler.
// Used by the controller, the datapath and the top level; no dependencies.
package kvts_pkg;

  localparam int TIME_W  = 24;
  localparam int COMP_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int NUM_COMP = 3;

  // Request kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [INDEX_W-1:0]       key_index;
    logic [TIME_W-1:0]        key_time;
    logic signed [COMP_W-1:0] key_x;
    logic signed [COMP_W-1:0] key_y;
    logic signed [COMP_W-1:0] key_z;
    logic [TIME_W-1:0]        sample_time;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_RDA,
    S_LDA,
    S_LDB,
    S_DEC,
    S_DIV,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_A,
    RD_B
  } rd_sel_t;

  typedef struct packed {
    logic    wr;
    logic    load;
    logic    zero;
    logic    cmp;
    rd_sel_t rd_sel;
    logic    lat_a;
    logic    lat_b;
    logic    take_a;
    logic    div_init;
    logic    div_step;
    logic    mul;
    logic    add;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic srch_done;
    logic edge_case;
    logic div_last;
    logic comp_last;
  } dp_sts_t;

endpackage

/* hw/rtl/kvts_ctrl.sv */
// Controller state machine of the keyframe vector track sampler.
// Depends on kvts_pkg; drives the datapath through ctl_cmd_t and reads dp_sts_t.
module kvts_ctrl
  import kvts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     kind,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_MID;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_WRITE) begin
            cmd.wr = 1'b1;
          end else if (sts.empty) begin
            cmd.zero   = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // The read of the middle entry is issued here.
        cmd.rd_sel = RD_MID;
        state_next = sts.srch_done ? S_RDA : S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_SRCH;
      end
      S_RDA: begin
        cmd.rd_sel = RD_A;
        state_next = S_LDA;
      end
      S_LDA: begin
        cmd.lat_a  = 1'b1;
        cmd.rd_sel = RD_B;
        state_next = S_LDB;
      end
      S_LDB: begin
        cmd.lat_b  = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.edge_case) begin
          cmd.take_a = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = sts.comp_last ? S_OUT : S_MUL;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

`ifndef SYNTH
  // A result is only ever given while a sample request is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a request");

  // An accepted sample request always leaves the idle state.
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && kind == KIND_SAMPLE) |=> busy)
    else $error("sample request not taken up");

  // The result cycle is followed by idle.
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result repeated");
`endif

endmodule

/* hw/rtl/kvts_dp.sv */
// Datapath of the keyframe vector track sampler: key memories, search,
// fraction divider and shared multiplier. Depends on kvts_pkg.
module kvts_dp
  import kvts_pkg::*;
#(
  parameter int MAX_KEYS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  input  req_t               req,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  output dp_sts_t            sts,
  output res_t               res
);

  localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW  = $clog2(MAX_KEYS + 1);
  localparam int CW  = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int DCW = $clog2(FRACTION_BITS + 1);
  localparam int PW  = COMP_W + 1 + FRACTION_BITS + 1;

  logic [COUNT_W-1:0] key_count;

  // Key memories.
  logic [TIME_W-1:0]                      time_mem [MAX_KEYS];
  logic [NUM_COMP-1:0][COMP_W-1:0]        vec_mem  [MAX_KEYS];
  logic [TIME_W-1:0]                      rd_time;
  logic [NUM_COMP-1:0][COMP_W-1:0]        rd_vec;
  logic [AW-1:0]                          rd_addr;

  logic [TIME_W-1:0] t_smp;
  logic [NW-1:0]     n_keys, low, high, mid, idx_a;
  logic [NW:0]       mid_sum;
  logic [CW-1:0]     kc_ext;

  logic [TIME_W-1:0]               t0, t1, den, rem;
  logic [TIME_W:0]                 rem2;
  logic [FRACTION_BITS-1:0]        frac;
  logic [DCW-1:0]                  div_cnt;
  logic [NUM_COMP-1:0][COMP_W-1:0] a_vec, b_vec;
  logic [1:0]                      comp;
  logic signed [COMP_W:0]          diff;
  logic signed [PW-1:0]            prod;
  logic signed [PW-1:0]            delta;
  logic [COMP_W-1:0]               a_sel;
  logic [NUM_COMP-1:0][COMP_W-1:0] out_vec;
  logic                            found;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // Effective key count, limited to the track depth.
  always_comb begin
    kc_ext = CW'(key_count);
    if (kc_ext > CW'(MAX_KEYS)) begin
      n_keys = NW'(MAX_KEYS);
    end else begin
      n_keys = NW'(kc_ext);
    end
  end

  // Search midpoint and the two neighbour indexes.
  assign mid_sum = {1'b0, low} + {1'b0, high};
  assign mid     = mid_sum[NW:1];
  assign idx_a   = (low == '0) ? '0 : low - NW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_A:    rd_addr = AW'(idx_a);
      RD_B:    rd_addr = AW'(low);
      default: rd_addr = AW'(mid);
    endcase
  end

  // Memory write on a keyframe request and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(req.key_index) < MAX_KEYS)) begin
      time_mem[AW'(req.key_index)] <= req.key_time;
      vec_mem[AW'(req.key_index)]  <= {req.key_z, req.key_y, req.key_x};
    end
    rd_time <= time_mem[rd_addr];
    rd_vec  <= vec_mem[rd_addr];
  end

  // Binary search for the first key later than the sample time.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_smp <= req.sample_time;
      low   <= '0;
      high  <= n_keys;
    end else if (cmd.cmp) begin
      if (rd_time <= t_smp) begin
        low <= mid + NW'(1);
      end else begin
        high <= mid;
      end
    end
  end

  // Neighbour keys.
  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      t0    <= rd_time;
      a_vec <= rd_vec;
    end
    if (cmd.lat_b) begin
      t1    <= rd_time;
      b_vec <= rd_vec;
    end
  end

  // Restoring divider, one quotient bit a cycle.
  assign rem2 = {rem, 1'b0};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= t_smp - t0;
      den     <= t1 - t0;
      frac    <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem  <= TIME_W'(rem2 - {1'b0, den});
        frac <= {frac[FRACTION_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem2[TIME_W-1:0];
        frac <= {frac[FRACTION_BITS-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DCW'(1);
    end
  end

  // Shared multiplier, one component at a time.
  assign a_sel = a_vec[comp];
  assign diff  = $signed({b_vec[comp][COMP_W-1], b_vec[comp]})
               - $signed({a_sel[COMP_W-1], a_sel});
  assign delta = prod >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'(diff) * PW'($signed({1'b0, frac}));
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.zero) begin
      found   <= 1'b0;
      out_vec <= '0;
    end else if (cmd.take_a) begin
      found   <= 1'b1;
      out_vec <= a_vec;
    end else if (cmd.div_init) begin
      found <= 1'b1;
      comp  <= '0;
    end else if (cmd.add) begin
      out_vec[comp] <= a_sel + delta[COMP_W-1:0];
      comp          <= comp + 2'd1;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.empty     = (key_count == '0);
    sts.srch_done = !(low < high);
    sts.edge_case = (low == '0) || (low >= n_keys) || (t1 <= t0) || (t_smp < t0);
    sts.div_last  = (div_cnt == DCW'(FRACTION_BITS - 1));
    sts.comp_last = (comp == 2'(NUM_COMP - 1));
  end

  assign res.found = found;
  assign res.out_x = out_vec[0];
  assign res.out_y = out_vec[1];
  assign res.out_z = out_vec[2];

endmodule

/* hw/rtl/keyframe_vector_track_sampler_top.sv */
// Top level of the keyframe vector track sampler.
// Depends on kvts_pkg, kvts_ctrl and kvts_dp.
//
//   Channel   Signals               Direction  Handshake
//   request   start, busy, req      in         taken when start and not busy
//   result    done, res             out        one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_data      in         key_count written when cfg_we
//
// A keyframe write is done in the idle state and leaves busy low.
// A sample runs each binary-search step (at most 7 for 64 keys) as a read and a
// compare, then sees the search end, fetches the neighbours and decides, runs the
// divider for FRACTION_BITS quotient bits, a multiply and an add per component, and
// gives the result; a new request is taken only once busy is low after the result.
// An empty track gives its result straight from the idle state; an end key or
// an out-of-order pair gives it right after the decision, with no divide.
// Reset clears the controller and key_count; key memories are not cleared.
module keyframe_vector_track_sampler_top
  import kvts_pkg::*;
#(
  parameter int MAX_KEYS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  output logic               done,
  output res_t               res,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  kvts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (req.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  kvts_dp #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sts      (sts),
    .res      (res)
  );

endmodule

/* test/keyframe_vector_track_sampler_top_tb.sv */
// Testbench for the keyframe vector track sampler: keyframe writes and track samples.
// It checks each sample result against a predictor of its own, written from the
// block's behaviour. Depends on kvts_pkg and keyframe_vector_track_sampler_top.
module keyframe_vector_track_sampler_top_tb;
  import kvts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRACK_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int DRAIN_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  req_t               req = '0;
  logic               done;
  res_t               res;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Predictor state: its own copy of the track and the key count.
  logic [TIME_W-1:0]        track_time [TRACK_DEPTH];
  logic signed [COMP_W-1:0] track_vec  [TRACK_DEPTH][NUM_COMP];
  int unsigned              track_count = 0;
  int                       written_slots = 0;

  req_t pending_reqs[$];
  res_t expected_samples[$];
  int   sender_idle_pct = 0;
  int   mismatches = 0;

  keyframe_vector_track_sampler_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop if the block hangs.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: %s", $realtime, what);
  endtask

  // Linear step of one component: a + floor((b - a) * f / 2^FRAC_BITS).
  function automatic logic signed [COMP_W-1:0] lerp_component(
    input logic signed [COMP_W-1:0] a, input logic signed [COMP_W-1:0] b,
    input longint frac);
    longint delta;
    longint prod;
    delta = longint'(b) - longint'(a);
    prod  = delta * frac;
    return COMP_W'(longint'(a) + (prod >>> FRAC_BITS));
  endfunction

  // Expected result of sampling the track at time t.
  function automatic res_t predict_sample(input logic [TIME_W-1:0] t);
    res_t r;
    int unsigned n, lo, hi, mid, k, sel;
    longint frac;
    r = '0;
    n = (track_count > TRACK_DEPTH) ? TRACK_DEPTH : track_count;
    if (n == 0) begin
      return r;
    end
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (track_time[mid] <= t) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    k = lo;
    r.found = 1'b1;
    if (k == 0 || k >= n) begin
      sel = (k == 0) ? 0 : n - 1;
      r.out_x = track_vec[sel][0];
      r.out_y = track_vec[sel][1];
      r.out_z = track_vec[sel][2];
    end else if (track_time[k] <= track_time[k-1] || t < track_time[k-1]) begin
      r.out_x = track_vec[k-1][0];
      r.out_y = track_vec[k-1][1];
      r.out_z = track_vec[k-1][2];
    end else begin
      frac = (longint'(t - track_time[k-1]) << FRAC_BITS) /
             longint'(track_time[k] - track_time[k-1]);
      r.out_x = lerp_component(track_vec[k-1][0], track_vec[k][0], frac);
      r.out_y = lerp_component(track_vec[k-1][1], track_vec[k][1], frac);
      r.out_z = lerp_component(track_vec[k-1][2], track_vec[k][2], frac);
    end
    return r;
  endfunction

  // Driver: offers the oldest pending request at the falling edge.
  always @(negedge clk) begin
    if (!rst && pending_reqs.size() > 0 &&
        $urandom_range(99, 0) >= sender_idle_pct) begin
      start <= 1'b1;
      req   <= pending_reqs[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted request and checks each result.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (done) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          want = expected_samples.pop_front();
          if (res.found !== want.found)
            report_mismatch($sformatf("found %b, wanted %b", res.found, want.found));
          if (res.out_x !== want.out_x)
            report_mismatch($sformatf("out_x %h, wanted %h", res.out_x, want.out_x));
          if (res.out_y !== want.out_y)
            report_mismatch($sformatf("out_y %h, wanted %h", res.out_y, want.out_y));
          if (res.out_z !== want.out_z)
            report_mismatch($sformatf("out_z %h, wanted %h", res.out_z, want.out_z));
        end
      end
      if (start && !busy) begin
        if (req.kind == KIND_WRITE) begin
          track_time[req.key_index]   = req.key_time;
          track_vec[req.key_index][0] = req.key_x;
          track_vec[req.key_index][1] = req.key_y;
          track_vec[req.key_index][2] = req.key_z;
        end else begin
          expected_samples.push_back(predict_sample(req.sample_time));
        end
        void'(pending_reqs.pop_front());
      end
    end
  end

  // Component value, with the extremes turning up often.
  function automatic logic signed [COMP_W-1:0] pick_component();
    case ($urandom_range(7, 0))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_key_write(input int slot, input logic [TIME_W-1:0] t);
    req_t r;
    r = '0;
    r.kind      = KIND_WRITE;
    r.key_index = INDEX_W'(slot);
    r.key_time  = t;
    r.key_x     = pick_component();
    r.key_y     = pick_component();
    r.key_z     = pick_component();
    r.sample_time = TIME_W'($urandom);
    pending_reqs.push_back(r);
    if (slot + 1 > written_slots) written_slots = slot + 1;
  endtask

  task automatic queue_sample(input logic [TIME_W-1:0] t);
    req_t r;
    r = '0;
    r.kind        = KIND_SAMPLE;
    r.key_index   = INDEX_W'($urandom);
    r.key_time    = TIME_W'($urandom);
    r.key_x       = $urandom;
    r.key_y       = $urandom;
    r.key_z       = $urandom;
    r.sample_time = t;
    pending_reqs.push_back(r);
  endtask

  // Wait until all requests are taken and all results are in, then let the block settle.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_samples.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(input int unsigned n);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= COUNT_W'(n);
    track_count = n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_items, nkeys, nsamp, j, cnt;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] key_times[TRACK_DEPTH];
    int idle_pcts[4];

    idle_pcts = '{0, 73, 73, 31};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty track, then a short track with a repeated time.
    queue_sample('0);
    queue_sample('1);
    queue_key_write(0, 24'd100);
    queue_key_write(1, 24'd300);
    queue_key_write(2, 24'd300);
    queue_key_write(3, 24'd1000);
    write_key_count(4);
    foreach (key_times[i]) key_times[i] = '0;
    queue_sample(24'd0);
    queue_sample(24'd99);
    queue_sample(24'd100);
    queue_sample(24'd150);
    queue_sample(24'd299);
    queue_sample(24'd300);
    queue_sample(24'd650);
    queue_sample(24'd1000);
    queue_sample('1);
    // Out-of-order pair: key 1 is given an earlier time than key 0, then sampled.
    queue_key_write(1, 24'd50);
    write_key_count(2);
    queue_sample(24'd60);
    queue_sample(24'd100);

    // Random phases: well-formed tracks with random content, some unsorted.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_pcts[phase];
      phase_items = 0;
      while (phase_items < 275) begin
        if ($urandom_range(9, 0) == 0) nkeys = TRACK_DEPTH;
        else nkeys = $urandom_range(12, 1);
        t = ($urandom_range(3, 0) == 0) ? TIME_W'($urandom_range(24'hffffff, 24'hf00000))
                                        : TIME_W'($urandom_range(500, 0));
        for (int s = 0; s < nkeys; s++) begin
          if ($urandom_range(9, 0) == 0) begin
            key_times[s] = TIME_W'($urandom);
          end else begin
            key_times[s] = t;
            if (t > 24'hffffff - 24'h1000) t = 24'hffffff;
            else t = t + TIME_W'($urandom_range(($urandom_range(1, 0) ? 16 : 4096), 0));
          end
          queue_key_write(s, key_times[s]);
        end
        case ($urandom_range(5, 0))
          0: cnt = $urandom_range(written_slots, 0);
          1: cnt = (written_slots == TRACK_DEPTH) ? $urandom_range(127, 65) : nkeys;
          default: cnt = nkeys;
        endcase
        write_key_count(cnt);
        nsamp = $urandom_range(20, 6);
        for (int s = 0; s < nsamp; s++) begin
          j = $urandom_range(nkeys - 1, 0);
          case ($urandom_range(5, 0))
            0: queue_sample(TIME_W'($urandom));
            1: queue_sample(key_times[j]);
            2: queue_sample(key_times[j] - TIME_W'(1));
            3: queue_sample(key_times[j] + TIME_W'(1));
            default: queue_sample(key_times[j] + TIME_W'($urandom_range(4096, 0)));
          endcase
        end
        phase_items += nkeys + nsamp;
      end
    end
    write_key_count(0);
    queue_sample(TIME_W'($urandom));
    wait_idle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* keyframe_vector_track_sampler_top.f */
hw/rtl/kvts_pkg.sv
hw/rtl/kvts_ctrl.sv
hw/rtl/kvts_dp.sv
hw/rtl/keyframe_vector_track_sampler_top.sv
test/keyframe_vector_track_sampler_top_tb.sv
